// ===== hdl/fdl_pkg.sv =====
// Package for the feedback delay line: configuration types, register
// indexes, reset values and the sequencer state encoding.
// No dependencies.
`default_nettype none

package fdl_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEPTH_DEF        = 65536;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TANH_ENTRIES_DEF = 1024;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [23:0] RST_DELAY_TARGET    = 24'd245760;
  localparam logic [14:0] RST_FEEDBACK_TARGET = 15'd0;
  localparam logic [15:0] RST_MIX_TARGET      = 16'd0;
  localparam logic        RST_EFFECT_ENABLED  = 1'b0;
  localparam logic [15:0] RST_PARAM_COEF      = 16'd45;
  localparam logic [15:0] RST_FADE_COEF       = 16'd136;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_TARGET    = 3'd0,
    CFG_FEEDBACK_TARGET = 3'd1,
    CFG_MIX_TARGET      = 3'd2,
    CFG_EFFECT_ENABLED  = 3'd3,
    CFG_PARAM_COEF      = 3'd4,
    CFG_FADE_COEF       = 3'd5
  } cfg_reg_t;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [23:0] delay_target;
    logic [14:0] feedback_target;
    logic [15:0] mix_target;
    logic        effect_enabled;
    logic [15:0] param_smooth_coef;
    logic [15:0] bypass_fade_coef;
  } cfg_t;

  // Sequencer steps, one per cycle unless waiting in idle or holding on a stalled output
  typedef enum logic [4:0] {
    ST_IDLE, ST_DLO, ST_DHI, ST_FB, ST_MIX, ST_FADE, ST_ADDR, ST_POS,
    ST_RDA, ST_RDB, ST_INT, ST_DLY, ST_FBM, ST_SUM, ST_TIX, ST_TB, ST_TD,
    ST_WR, ST_WET1, ST_WET2, ST_WET3, ST_MA, ST_MB, ST_MC, ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/fdl_delay_ram.sv =====
// Delay line storage: one synchronous memory, one write and one read port,
// read data registered. Depends on nothing.
`default_nettype none

module fdl_delay_ram #(
  parameter int DEPTH = 65536,
  parameter int SW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic signed [SW-1:0]     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [SW-1:0]          rdata
);

  logic signed [SW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/fdl_tanh_rom.sv =====
// Soft limiter table: tanh over [-2,2] in TE+1 points, built at elaboration
// and read through a registered port. Depends on nothing.
`default_nettype none

module fdl_tanh_rom #(
  parameter int SW = 16,
  parameter int TE = 1024
) (
  input  wire logic                    clk,
  input  wire logic [$clog2(TE+1)-1:0] addr,
  output logic signed [SW-1:0]         q
);

  localparam int          FRAC = SW - 1;
  localparam logic [63:0] Q28  = 64'd1 << 28;

  typedef logic signed [SW-1:0] tab_arr_t [TE+1];

  // Restoring long division for elaboration-time table construction
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] r;
    logic [63:0] qq;
    r  = '0;
    qq = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, dvs}) begin
        r     = r - {1'b0, dvs};
        qq[k] = 1'b1;
      end
    end
    return qq;
  endfunction

  // One table point: series for exp(2|x|) in Q28, then rounded ratio
  function automatic logic signed [SW-1:0] tanh_point(input int i);
    longint      kk;
    logic [63:0] a;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] v;
    logic        done;
    kk   = 4 * longint'(i) - 2 * longint'(TE);
    a    = (kk < 0) ? 64'(-kk) : 64'(kk);
    y    = udiv64(a << 29, 64'(TE));
    sum  = Q28;
    term = Q28;
    done = 1'b0;
    for (int n = 1; n <= 64; n++) begin
      if (!done) begin
        term = udiv64((term * y) >> 28, 64'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    num = (sum - Q28) << FRAC;
    den = sum + Q28;
    v   = udiv64(num + (den >> 1), den);
    return (kk < 0) ? -SW'(v) : SW'(v);
  endfunction

  function automatic tab_arr_t build_tab();
    tab_arr_t t;
    for (int i = 0; i <= TE; i++) begin
      t[i] = tanh_point(i);
    end
    return t;
  endfunction

  localparam tab_arr_t TAB = build_tab();

  // Registered table read
  always_ff @(posedge clk) begin
    q <= TAB[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/fdl_core.sv =====
// Sequencer and datapath of the feedback delay line: parameter smoothing,
// fractional read, soft limiter, write back and dry/wet mix on one shared
// multiplier. Depends on fdl_pkg, fdl_delay_ram and fdl_tanh_rom.
`default_nettype none

module fdl_core #(
  parameter int DEPTH        = fdl_pkg::DEPTH_DEF,
  parameter int SW           = fdl_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_ENTRIES = fdl_pkg::TANH_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fdl_pkg::cfg_t        cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [SW-1:0] in_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [SW-1:0]      out_sample
);

  localparam int AW   = $clog2(DEPTH);
  localparam int TAW  = $clog2(TANH_ENTRIES + 1);
  localparam int PW   = AW + 9;
  localparam int CW   = (AW + 8 > 24) ? AW + 9 : 25;
  localparam int FRAC = SW - 1;

  localparam logic [CW-1:0] D_MIN = CW'(256);
  localparam logic [CW-1:0] D_MAX = CW'((DEPTH - 2) * 256);
  localparam logic [PW-1:0] DSPAN = PW'(DEPTH * 256);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [TAW-1:0] TEND = TAW'(TANH_ENTRIES);

  localparam logic signed [SW+1:0] LIM_HI = signed'((SW + 2)'(1) << SW);
  localparam logic signed [SW+1:0] LIM_LO = -LIM_HI;
  localparam logic signed [63:0]   Y_MAX  = (64'sd1 <<< FRAC) - 64'sd1;
  localparam logic signed [63:0]   Y_MIN  = -(64'sd1 <<< FRAC);
  localparam logic [32:0]          Q31_ONE = 33'h0_8000_0000;
  localparam logic [31:0]          FADE_ON = 32'h8000_0000;

  // Control and smoothed state
  fdl_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic            full_r, full_nxt;
  logic [39:0]     dcur_r, dcur_nxt;
  logic [31:0]     fbcur_r, fbcur_nxt;
  logic [31:0]     mixcur_r, mixcur_nxt;
  logic [31:0]     fade_r, fade_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Per-word working registers
  logic signed [SW-1:0] x_r, x_nxt;
  logic signed [63:0]   acc_r, acc_nxt;
  logic signed [60:0]   prod_r;
  logic [AW+7:0]        d_r, d_nxt;
  logic [AW-1:0]        ia_r, ia_nxt;
  logic [AW-1:0]        ib_r, ib_nxt;
  logic [7:0]           frac_r, frac_nxt;
  logic signed [SW-1:0] a_r, a_nxt;
  logic signed [SW-1:0] delayed_r, delayed_nxt;
  logic                 sat_lo_r, sat_lo_nxt;
  logic                 sat_hi_r, sat_hi_nxt;
  logic [TAW-1:0]       idx_r, idx_nxt;
  logic [SW:0]          rem_r, rem_nxt;
  logic signed [SW-1:0] ta_r, ta_nxt;
  logic [31:0]          wet_r, wet_nxt;
  logic signed [SW-1:0] out_sample_r, out_sample_nxt;

  // Memory and multiplier hookup
  logic                 ram_we;
  logic signed [SW-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic signed [SW-1:0] ram_q;
  logic [TAW-1:0]       rom_addr;
  logic signed [SW-1:0] rom_q;
  logic signed [33:0]   mul_a;
  logic signed [26:0]   mul_b;

  // Combinational helpers
  logic [15:0]          mt;
  logic signed [40:0]   diff_d;
  logic signed [32:0]   diff_fb;
  logic signed [32:0]   diff_mix;
  logic signed [32:0]   diff_fade;
  logic [CW-1:0]        d_raw;
  logic [PW-1:0]        pos_sum;
  logic [PW-1:0]        pos_w;
  logic                 vld_a;
  logic                 vld_b;
  logic signed [SW-1:0] bval;
  logic signed [SW+1:0] tsum;
  logic signed [SW+1:0] v;
  logic [SW:0]          u;
  logic signed [SW:0]   dtab;
  logic [32:0]          om;
  logic signed [63:0]   y;

  fdl_delay_ram #(.DEPTH(DEPTH), .SW(SW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  fdl_tanh_rom #(.SW(SW), .TE(TANH_ENTRIES)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Smoothing differences against the targets
  always_comb begin
    mt        = (cfg.mix_target > 16'd32768) ? 16'd32768 : cfg.mix_target;
    diff_d    = signed'({1'b0, cfg.delay_target, 16'b0}) - signed'({1'b0, dcur_r});
    diff_fb   = signed'({2'b0, cfg.feedback_target, 16'b0}) - signed'({1'b0, fbcur_r});
    diff_mix  = signed'({1'b0, mt, 16'b0}) - signed'({1'b0, mixcur_r});
    diff_fade = signed'({1'b0, (cfg.effect_enabled ? FADE_ON : 32'd0)})
              - signed'({1'b0, fade_r});
  end

  // Read position behind the write pointer
  always_comb begin
    d_raw   = CW'(dcur_r[39:16]);
    pos_sum = PW'({wp_r, 8'b0}) + DSPAN - PW'(d_r);
    pos_w   = (pos_sum >= DSPAN) ? pos_sum - DSPAN : pos_sum;
    vld_a   = full_r || (ia_r < wp_r);
    vld_b   = full_r || (ib_r < wp_r);
    bval    = vld_b ? ram_q : '0;
    tsum    = (SW + 2)'(a_r) + (SW + 2)'(prod_r >>> 8);
    v       = (SW + 2)'(x_r) + (SW + 2)'(prod_r >>> 15);
    u       = (SW + 1)'(v + LIM_HI);
    dtab    = (SW + 1)'(rom_q) - (SW + 1)'(ta_r);
    om      = Q31_ONE - {1'b0, wet_r};
    y       = acc_r >>> 31;
  end

  // Next state, datapath and memory control
  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    full_nxt       = full_r;
    dcur_nxt       = dcur_r;
    fbcur_nxt      = fbcur_r;
    mixcur_nxt     = mixcur_r;
    fade_nxt       = fade_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    d_nxt          = d_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    frac_nxt       = frac_r;
    a_nxt          = a_r;
    delayed_nxt    = delayed_r;
    sat_lo_nxt     = sat_lo_r;
    sat_hi_nxt     = sat_hi_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    ta_nxt         = ta_r;
    wet_nxt        = wet_r;
    out_sample_nxt = out_sample_r;
    ram_we         = 1'b0;
    ram_wdata      = '0;
    ram_raddr      = ia_r;
    rom_addr       = idx_r;
    mul_a          = '0;
    mul_b          = '0;

    // Drop the result word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fdl_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          state_nxt = fdl_pkg::ST_DLO;
        end
      end
      // Delay smoothing, low and high parts of the difference
      fdl_pkg::ST_DLO: begin
        mul_a     = 34'(signed'({1'b0, diff_d[23:0]}));
        mul_b     = 27'(signed'({1'b0, cfg.param_smooth_coef}));
        state_nxt = fdl_pkg::ST_DHI;
      end
      fdl_pkg::ST_DHI: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = 34'(signed'(diff_d[40:24]));
        mul_b     = 27'(signed'({1'b0, cfg.param_smooth_coef}));
        state_nxt = fdl_pkg::ST_FB;
      end
      fdl_pkg::ST_FB: begin
        acc_nxt   = acc_r + (64'(prod_r) <<< 24);
        mul_a     = 34'(diff_fb);
        mul_b     = 27'(signed'({1'b0, cfg.param_smooth_coef}));
        state_nxt = fdl_pkg::ST_MIX;
      end
      fdl_pkg::ST_MIX: begin
        dcur_nxt  = 40'(64'(signed'({1'b0, dcur_r})) + (acc_r >>> 16));
        fbcur_nxt = 32'(64'(signed'({1'b0, fbcur_r})) + 64'(prod_r >>> 16));
        mul_a     = 34'(diff_mix);
        mul_b     = 27'(signed'({1'b0, cfg.param_smooth_coef}));
        state_nxt = fdl_pkg::ST_FADE;
      end
      fdl_pkg::ST_FADE: begin
        mixcur_nxt = 32'(64'(signed'({1'b0, mixcur_r})) + 64'(prod_r >>> 16));
        mul_a      = 34'(diff_fade);
        mul_b      = 27'(signed'({1'b0, cfg.bypass_fade_coef}));
        state_nxt  = fdl_pkg::ST_ADDR;
      end
      // Clamp the delay, then locate the two taps
      fdl_pkg::ST_ADDR: begin
        fade_nxt = 32'(64'(signed'({1'b0, fade_r})) + 64'(prod_r >>> 16));
        if (d_raw < D_MIN) begin
          d_nxt = (AW + 8)'(D_MIN);
        end else if (d_raw > D_MAX) begin
          d_nxt = (AW + 8)'(D_MAX);
        end else begin
          d_nxt = (AW + 8)'(d_raw);
        end
        state_nxt = fdl_pkg::ST_POS;
      end
      fdl_pkg::ST_POS: begin
        ia_nxt    = pos_w[AW+7:8];
        ib_nxt    = (pos_w[AW+7:8] == LAST) ? '0 : pos_w[AW+7:8] + AW'(1);
        frac_nxt  = pos_w[7:0];
        state_nxt = fdl_pkg::ST_RDA;
      end
      fdl_pkg::ST_RDA: begin
        ram_raddr = ia_r;
        state_nxt = fdl_pkg::ST_RDB;
      end
      fdl_pkg::ST_RDB: begin
        a_nxt     = vld_a ? ram_q : '0;
        ram_raddr = ib_r;
        state_nxt = fdl_pkg::ST_INT;
      end
      // Linear interpolation between the taps
      fdl_pkg::ST_INT: begin
        mul_a     = 34'((SW + 1)'(bval) - (SW + 1)'(a_r));
        mul_b     = 27'(signed'({1'b0, frac_r}));
        state_nxt = fdl_pkg::ST_DLY;
      end
      fdl_pkg::ST_DLY: begin
        delayed_nxt = tsum[SW-1:0];
        state_nxt   = fdl_pkg::ST_FBM;
      end
      fdl_pkg::ST_FBM: begin
        mul_a     = 34'(delayed_r);
        mul_b     = 27'(signed'({1'b0, fbcur_r[31:16]}));
        state_nxt = fdl_pkg::ST_SUM;
      end
      // Limiter input and table index
      fdl_pkg::ST_SUM: begin
        sat_lo_nxt = (v < LIM_LO);
        sat_hi_nxt = (v >= LIM_HI);
        mul_a      = 34'(signed'({1'b0, u}));
        mul_b      = 27'(TANH_ENTRIES);
        state_nxt  = fdl_pkg::ST_TIX;
      end
      fdl_pkg::ST_TIX: begin
        if (sat_lo_r) begin
          idx_nxt = '0;
          rem_nxt = '0;
        end else if (sat_hi_r) begin
          idx_nxt = TEND;
          rem_nxt = '0;
        end else begin
          idx_nxt = TAW'(prod_r >>> (SW + 1));
          rem_nxt = prod_r[SW:0];
        end
        rom_addr  = idx_nxt;
        state_nxt = fdl_pkg::ST_TB;
      end
      fdl_pkg::ST_TB: begin
        ta_nxt    = rom_q;
        rom_addr  = (idx_r == TEND) ? idx_r : idx_r + TAW'(1);
        state_nxt = fdl_pkg::ST_TD;
      end
      fdl_pkg::ST_TD: begin
        mul_a     = 34'(dtab);
        mul_b     = 27'(signed'({1'b0, rem_r}));
        state_nxt = fdl_pkg::ST_WR;
      end
      // Write the limited value back and advance the pointer
      fdl_pkg::ST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = SW'((SW + 1)'(ta_r) + (SW + 1)'(prod_r >>> (SW + 1)));
        if (wp_r == LAST) begin
          wp_nxt   = '0;
          full_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + AW'(1);
        end
        mul_a     = 34'(signed'({1'b0, mixcur_r}));
        mul_b     = 27'(signed'({1'b0, fade_r[15:0]}));
        state_nxt = fdl_pkg::ST_WET1;
      end
      // Wet gain from mix and enable fade
      fdl_pkg::ST_WET1: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = 34'(signed'({1'b0, mixcur_r}));
        mul_b     = 27'(signed'({1'b0, fade_r[31:16]}));
        state_nxt = fdl_pkg::ST_WET2;
      end
      fdl_pkg::ST_WET2: begin
        acc_nxt   = acc_r + (64'(prod_r) <<< 16);
        state_nxt = fdl_pkg::ST_WET3;
      end
      fdl_pkg::ST_WET3: begin
        wet_nxt   = 32'(acc_r >>> 31);
        state_nxt = fdl_pkg::ST_MA;
      end
      // Crossfade dry and delayed
      fdl_pkg::ST_MA: begin
        mul_a     = 34'(signed'({1'b0, om}));
        mul_b     = 27'(x_r);
        state_nxt = fdl_pkg::ST_MB;
      end
      fdl_pkg::ST_MB: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = 34'(signed'({1'b0, wet_r}));
        mul_b     = 27'(delayed_r);
        state_nxt = fdl_pkg::ST_MC;
      end
      fdl_pkg::ST_MC: begin
        acc_nxt   = acc_r + 64'(prod_r);
        state_nxt = fdl_pkg::ST_OUT;
      end
      // Hold until the output register is free
      fdl_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (y > Y_MAX) begin
            out_sample_nxt = Y_MAX[SW-1:0];
          end else if (y < Y_MIN) begin
            out_sample_nxt = Y_MIN[SW-1:0];
          end else begin
            out_sample_nxt = y[SW-1:0];
          end
          state_nxt = fdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and smoothed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdl_pkg::ST_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      dcur_r      <= {fdl_pkg::RST_DELAY_TARGET, 16'b0};
      fbcur_r     <= {1'b0, fdl_pkg::RST_FEEDBACK_TARGET, 16'b0};
      mixcur_r    <= {fdl_pkg::RST_MIX_TARGET, 16'b0};
      fade_r      <= fdl_pkg::RST_EFFECT_ENABLED ? FADE_ON : 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      dcur_r      <= dcur_nxt;
      fbcur_r     <= fbcur_nxt;
      mixcur_r    <= mixcur_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    d_r          <= d_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    frac_r       <= frac_nxt;
    a_r          <= a_nxt;
    delayed_r    <= delayed_nxt;
    sat_lo_r     <= sat_lo_nxt;
    sat_hi_r     <= sat_hi_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    ta_r         <= ta_nxt;
    wet_r        <= wet_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign in_stall   = (state_r != fdl_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Accepted word keeps the sequencer busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer took a word but stayed idle");

  // Write pointer steps by one per write back, wrapping at the end
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdl_pkg::ST_WR) |=>
      (wp_r == (($past(wp_r) == LAST) ? '0 : $past(wp_r) + AW'(1))))
    else $error("write pointer did not advance by one");

  // Older tap never lands on the entry about to be written
  a_read_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdl_pkg::ST_RDA) |-> (ia_r != wp_r))
    else $error("read tap collides with write pointer");

  // Clamped delay stays inside the line
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fdl_pkg::ST_POS) |->
      ((CW'(d_r) >= D_MIN) && (CW'(d_r) <= D_MAX)))
    else $error("clamped delay out of range");

  // Fill flag never drops once the line has wrapped
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("fill flag dropped");

endmodule

`default_nettype wire

// ===== hdl/feedback_delay_line.sv =====
// Top level of the feedback delay line: configuration registers and the
// sequenced core. Depends on fdl_pkg and fdl_core.
//
//   port group   direction  handshake          payload
//   in_          to block   in_valid/in_stall  in_sample_in (signed)
//   out_         from block out_valid/out_stall out_sample_out (signed)
//   cfg_         to block   cfg_we             cfg_index, cfg_wdata
//
// A word passes through every step of the sequence from acceptance to a loaded
// output register, and the next word is taken only once the sequencer is back
// in idle; the pace is set by the step sequence around the single shared
// multiplier and the registered reads of the delay memory and the tanh table.
// Reset (rst_n low, synchronous) clears configuration, control and smoothed state; the delay
// memory is not swept, a fill flag and the write pointer make unwritten
// entries read as zero, so words are accepted right after reset.
// A stalled result waits in the output register; the next word is accepted
// meanwhile and holds in its final step until that register frees.
`default_nettype none

module feedback_delay_line #(
  parameter int DEPTH        = fdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = fdl_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_ENTRIES = fdl_pkg::TANH_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out,
  input  wire logic                             cfg_we,
  input  wire logic [fdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  fdl_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode register writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fdl_pkg::CFG_DELAY_TARGET:    cfg_nxt.delay_target      = cfg_wdata[23:0];
        fdl_pkg::CFG_FEEDBACK_TARGET: cfg_nxt.feedback_target   = cfg_wdata[14:0];
        fdl_pkg::CFG_MIX_TARGET:      cfg_nxt.mix_target        = cfg_wdata[15:0];
        fdl_pkg::CFG_EFFECT_ENABLED:  cfg_nxt.effect_enabled    = cfg_wdata[0];
        fdl_pkg::CFG_PARAM_COEF:      cfg_nxt.param_smooth_coef = cfg_wdata[15:0];
        fdl_pkg::CFG_FADE_COEF:       cfg_nxt.bypass_fade_coef  = cfg_wdata[15:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_target      <= fdl_pkg::RST_DELAY_TARGET;
      cfg_r.feedback_target   <= fdl_pkg::RST_FEEDBACK_TARGET;
      cfg_r.mix_target        <= fdl_pkg::RST_MIX_TARGET;
      cfg_r.effect_enabled    <= fdl_pkg::RST_EFFECT_ENABLED;
      cfg_r.param_smooth_coef <= fdl_pkg::RST_PARAM_COEF;
      cfg_r.bypass_fade_coef  <= fdl_pkg::RST_FADE_COEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fdl_core #(
    .DEPTH        (DEPTH),
    .SW           (SAMPLE_WIDTH),
    .TANH_ENTRIES (TANH_ENTRIES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out)
  );

endmodule

`default_nettype wire

// ===== bench/tb_feedback_delay_line.sv =====
// Self-checking bench for feedback_delay_line: drives audio words, random gaps
// and stalls, predicts each output word in fixed point. Depends on the DUT and
// fdl_pkg. Covers register writes, clamping, the limiter and random streams.
`default_nettype none

module tb_feedback_delay_line;

  localparam int LINE_DEPTH = 65536;
  localparam int TAB_POINTS = 1024;
  localparam longint Q31_UNITY = 64'sd1 << 31;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam logic [fdl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [fdl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  feedback_delay_line i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  int tanh_lut [0:TAB_POINTS];
  int echo_mem [0:LINE_DEPTH-1];
  int unsigned echo_wr;
  longint delay_cur, fbk_cur, mix_cur, fade_cur;
  logic [23:0] delay_tgt;
  logic [14:0] fbk_tgt;
  logic [15:0] mix_tgt;
  logic fx_on;
  logic [15:0] par_coef, fade_coef;

  logic signed [15:0] expected_words [$];
  int mismatches = 0;
  int gap_max = 15;
  int stall_max = 15;
  int stall_left = 0;
  longint cycles = 0;

  initial forever #1 clk = ~clk;

  // Run-time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int tanh_point(int i);
    longint k;
    longint unsigned a, y, sum, term, num, den, v;
    k = 4 * longint'(i) - 2 * TAB_POINTS;
    a = (k < 0) ? -k : k;
    y = (a << 29) / TAB_POINTS;
    sum = 64'd1 << 28;
    term = 64'd1 << 28;
    for (int n = 1; n <= 64; n++) begin
      term = ((term * y) >> 28) / n;
      if (term == 0) break;
      sum += term;
    end
    num = (sum - (64'd1 << 28)) << 15;
    den = sum + (64'd1 << 28);
    v = (num + den / 2) / den;
    return (k < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic longint glide(longint cur, longint tgt, logic [15:0] coef);
    return cur + (((tgt - cur) * longint'(coef)) >>> 16);
  endfunction

  function automatic longint soft_clip(longint v);
    longint p, idx, rem, d;
    if (v < -65536) return longint'(tanh_lut[0]);
    if (v >= 65536) return longint'(tanh_lut[TAB_POINTS]);
    p = (v + 65536) * TAB_POINTS;
    idx = p >> 17;
    rem = p & 131071;
    d = longint'(tanh_lut[idx + 1]) - longint'(tanh_lut[idx]);
    return longint'(tanh_lut[idx]) + ((d * rem) >>> 17);
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i <= TAB_POINTS; i++) tanh_lut[i] = tanh_point(i);
    for (int i = 0; i < LINE_DEPTH; i++) echo_mem[i] = 0;
    delay_tgt = fdl_pkg::RST_DELAY_TARGET;
    fbk_tgt = fdl_pkg::RST_FEEDBACK_TARGET;
    mix_tgt = fdl_pkg::RST_MIX_TARGET;
    fx_on = fdl_pkg::RST_EFFECT_ENABLED;
    par_coef = fdl_pkg::RST_PARAM_COEF;
    fade_coef = fdl_pkg::RST_FADE_COEF;
    echo_wr = 0;
    delay_cur = longint'(delay_tgt) << 16;
    fbk_cur = 0;
    mix_cur = 0;
    fade_cur = 0;
  endtask

  // Advance the predictor by one input word
  function automatic logic signed [15:0] echo_step(logic signed [15:0] s);
    longint x, d, pos, a, b, dly, wet, acc, y;
    int unsigned ia, ib;
    longint mt;
    x = s;
    mt = (mix_tgt > 16'd32768) ? 32768 : mix_tgt;
    delay_cur = glide(delay_cur, longint'(delay_tgt) << 16, par_coef);
    fbk_cur = glide(fbk_cur, longint'(fbk_tgt) << 16, par_coef);
    mix_cur = glide(mix_cur, mt << 16, par_coef);
    d = delay_cur >>> 16;
    if (d < 256) d = 256;
    if (d > longint'(LINE_DEPTH - 2) * 256) d = longint'(LINE_DEPTH - 2) * 256;
    pos = longint'(echo_wr) * 256 + longint'(LINE_DEPTH) * 256 - d;
    if (pos >= longint'(LINE_DEPTH) * 256) pos -= longint'(LINE_DEPTH) * 256;
    ia = pos >> 8;
    if (ia >= LINE_DEPTH) ia = 0;
    ib = ia + 1;
    if (ib >= LINE_DEPTH) ib = 0;
    a = echo_mem[ia];
    b = echo_mem[ib];
    dly = a + (((b - a) * (pos & 255)) >>> 8);
    echo_mem[echo_wr] = int'(soft_clip(x + ((dly * (fbk_cur >>> 16)) >>> 15)));
    echo_wr = (echo_wr + 1) % LINE_DEPTH;
    fade_cur = glide(fade_cur, fx_on ? Q31_UNITY : 64'sd0, fade_coef);
    // both factors lie in [0, 2^31], so the product stays non-negative
    wet = (mix_cur * fade_cur) >>> 31;
    acc = x * (Q31_UNITY - wet) + dly * wet;
    y = acc >>> 31;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  // Send one word after a random gap; valid stays high into the next call
  task automatic send_word(logic signed [15:0] s);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    expected_words.push_back(echo_step(s));
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [fdl_pkg::CFG_IDX_W-1:0] idx,
                           logic [fdl_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fdl_pkg::CFG_DELAY_TARGET:    delay_tgt = val[23:0];
      fdl_pkg::CFG_FEEDBACK_TARGET: fbk_tgt = val[14:0];
      fdl_pkg::CFG_MIX_TARGET:      mix_tgt = val[15:0];
      fdl_pkg::CFG_EFFECT_ENABLED:  fx_on = val[0];
      fdl_pkg::CFG_PARAM_COEF:      par_coef = val[15:0];
      fdl_pkg::CFG_FADE_COEF:       fade_coef = val[15:0];
      default: ;
    endcase
  endtask

  // Check each accepted output word; draw the next stall
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d", out_sample_out);
      end else begin
        if (out_sample_out !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d actual %0d",
                     expected_words[0], out_sample_out);
        end
        void'(expected_words.pop_front());
      end
      stall_left = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_sample_extremes();
    logic signed [15:0] pick [6] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sh5555};
    write_reg(fdl_pkg::CFG_PARAM_COEF, 24'd65535);
    write_reg(fdl_pkg::CFG_FADE_COEF, 24'd65535);
    write_reg(fdl_pkg::CFG_EFFECT_ENABLED, 24'd1);
    write_reg(fdl_pkg::CFG_MIX_TARGET, 24'd16384);
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'd640);
    foreach (pick[i]) send_word(pick[i]);
    drain();
  endtask

  task automatic test_delay_clamp();
    // hold the delay below one sample, then past the line end, then at the upper limit
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'd0);
    write_reg(fdl_pkg::CFG_MIX_TARGET, 24'd32768);
    for (int i = 0; i < 4; i++) send_word(16'($urandom));
    drain();
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'hFFFFFF);
    for (int i = 0; i < 3; i++) send_word(16'($urandom));
    drain();
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'd16776704);
    for (int i = 0; i < 2; i++) send_word(16'($urandom));
    drain();
  endtask

  task automatic test_limiter_and_mix();
    // drive the limiter toward both ends with feedback at 0.9, mix target above one
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'd256);
    write_reg(fdl_pkg::CFG_FEEDBACK_TARGET, 24'd29491);
    write_reg(fdl_pkg::CFG_MIX_TARGET, 24'd65535);
    for (int i = 0; i < 5; i++) send_word(16'sd32767);
    for (int i = 0; i < 5; i++) send_word(-16'sd32768);
    drain();
  endtask

  task automatic test_frozen_coefs();
    write_reg(fdl_pkg::CFG_PARAM_COEF, 24'd0);
    write_reg(fdl_pkg::CFG_FADE_COEF, 24'd0);
    write_reg(fdl_pkg::CFG_EFFECT_ENABLED, 24'd0);
    write_reg(fdl_pkg::CFG_DELAY_TARGET, 24'd5000);
    for (int i = 0; i < 3; i++) send_word(16'($urandom));
    drain();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE_LO, 24'hFFFFFF);
    write_reg(CFG_SPARE_HI, 24'h000000);
    for (int i = 0; i < 2; i++) send_word(16'($urandom));
    drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 10; ph++) begin
      gap_max = (ph % 4 == 0) ? 0 : 15;
      stall_max = (ph % 3 == 0) ? 0 : 15;
      write_reg(fdl_pkg::CFG_DELAY_TARGET,
                (ph == 9) ? 24'hFFFFFF : 24'($urandom_range(40 * 256, 0)));
      write_reg(fdl_pkg::CFG_FEEDBACK_TARGET,
                (ph == 8) ? 24'd29491 : 24'($urandom_range(29491, 0)));
      write_reg(fdl_pkg::CFG_MIX_TARGET,
                (ph == 7) ? 24'd0 : 24'($urandom_range(40000, 0)));
      write_reg(fdl_pkg::CFG_EFFECT_ENABLED, 24'($urandom_range(1, 0) | (ph < 3)));
      write_reg(fdl_pkg::CFG_PARAM_COEF,
                (ph == 6) ? 24'd65535 : 24'($urandom_range(65535, 0)));
      write_reg(fdl_pkg::CFG_FADE_COEF,
                (ph == 5) ? 24'd65535 : 24'($urandom_range(65535, 0)));
      for (int i = 0; i < 62; i++) send_word(16'($urandom));
      drain();
    end
  endtask

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_delay_clamp();
    test_limiter_and_mix();
    test_frozen_coefs();
    test_spare_index();
    test_random_settings();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== feedback_delay_line.f =====
hdl/fdl_pkg.sv
hdl/fdl_delay_ram.sv
hdl/fdl_tanh_rom.sv
hdl/fdl_core.sv
hdl/feedback_delay_line.sv
bench/tb_feedback_delay_line.sv
